[hdl/pose_error_signed_distance_assert.svh]
// ----------------------------------------------------------------------------
// Pose error assertion macros
// Short forms for the concurrent assertions of the pose error checker.
// ----------------------------------------------------------------------------
`ifndef POSE_ERROR_SIGNED_DISTANCE_ASSERT_SVH
`define POSE_ERROR_SIGNED_DISTANCE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define PESD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("pesd: invariant violated");

// A condition that must hold in the same cycle as its trigger.
`define PESD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pesd: implication violated");

// A condition that must hold a fixed number of cycles after its trigger.
`define PESD_ASSERT_DELAY(lbl, clk, rst_n, ante, lat, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
		else $error("pesd: delayed response missing");

`endif

[hdl/pesd_pkg.sv]
// ----------------------------------------------------------------------------
// Pose error package
// Constants, the arctangent table, shared types and depth helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pesd_pkg;

	localparam int OUT_WIDTH          = 22;
	localparam int OUT_MAX            = 2097151;
	localparam int DIST_WIDTH         = 21;
	localparam int Z_WIDTH            = 27;
	localparam int MOD_WIDTH          = 17;
	localparam int FINE_WIDTH         = 25;
	localparam int TURN_UNITS         = 92160;
	localparam int HALF_TURN_UNITS    = 46080;
	localparam int FINE_HALF          = 11796480;
	localparam int FINE_QUARTER       = 5898240;
	localparam int FINE_THREE_QUARTER = 17694720;
	localparam int TURN_LOW_BITS      = 11;
	localparam int TURN_ODD           = 45;
	localparam int RECIP_45           = 93207;
	localparam int RECIP_SHIFT        = 22;

	// Side-band that travels with an item through the late stages.
	typedef struct packed {
		logic                  valid;
		logic                  mode;
		logic [7:0]            low;
		logic [DIST_WIDTH-1:0] mag;
	} side_t;

	// Arctangent of 2^-i in units of 2^-16 degree, rounded to nearest.
	function automatic logic [21:0] atan_fine(input int idx);
		logic [21:0] val;
		case (idx)
			0: val = 22'd2949120;
			1: val = 22'd1740967;
			2: val = 22'd919879;
			3: val = 22'd466945;
			4: val = 22'd234379;
			5: val = 22'd117304;
			6: val = 22'd58666;
			7: val = 22'd29335;
			8: val = 22'd14668;
			9: val = 22'd7334;
			10: val = 22'd3667;
			11: val = 22'd1833;
			12: val = 22'd917;
			13: val = 22'd458;
			14: val = 22'd229;
			15: val = 22'd115;
			16: val = 22'd57;
			17: val = 22'd29;
			18: val = 22'd14;
			19: val = 22'd7;
			20: val = 22'd4;
			21: val = 22'd2;
			22: val = 22'd1;
			default: val = 22'd0;
		endcase
		return val;
	endfunction

	// Stage count of the shared iteration span (root and bearing).
	function automatic int pesd_depth(input int pos_width, input int cordic_steps);
		return (cordic_steps > pos_width + 2) ? cordic_steps : pos_width + 2;
	endfunction

	// Cycles from an accepted beat to its result strobe.
	function automatic int pesd_latency(input int pos_width, input int cordic_steps);
		return pesd_depth(pos_width, cordic_steps) + 8;
	endfunction

endpackage

[hdl/pesd_sqrt.sv]
// ----------------------------------------------------------------------------
// Pose error distance root
// Squares the offsets, sums them and takes a rounded integer square root
// one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pesd_sqrt #(
	parameter int POS_WIDTH = 20,
	parameter int DEPTH     = 22
) (
	input  logic                   clk,
	input  logic signed [POS_WIDTH:0] dx,
	input  logic signed [POS_WIDTH:0] dy,
	output logic [POS_WIDTH+1:0]   root
);
	import pesd_pkg::*;

	localparam int RW = POS_WIDTH + 1;
	localparam int NW = 2 * POS_WIDTH + 2;

	logic [NW-1:0] sqx_s0;
	logic [NW-1:0] sqy_s0;
	logic [NW-1:0] n_s    [DEPTH+1];
	logic [RW+1:0] rem_s  [DEPTH+1];
	logic [RW-1:0] root_s [DEPTH+1];

	// Squares of the signed offsets are never negative; the operands are
	// widened first so the product keeps all of its bits.
	always_ff @(posedge clk) begin
		sqx_s0 <= NW'($unsigned(NW'(dx) * NW'(dx)));
		sqy_s0 <= NW'($unsigned(NW'(dy) * NW'(dy)));
	end

	assign n_s[0]    = '0;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		if (k == 0) begin : g_sum
			// First stage forms the sum of squares.
			always_ff @(posedge clk) begin
				n_s[1]    <= sqx_s0 + sqy_s0;
				rem_s[1]  <= '0;
				root_s[1] <= '0;
			end
		end else if (k <= RW) begin : g_bit
			localparam int B = RW - k;
			logic [RW+3:0] trial;
			logic [RW+3:0] sub;
			logic          take;
			// Restoring step on the next pair of radicand bits.
			always_comb begin
				trial = {rem_s[k], n_s[k][2*B+1:2*B]};
				sub   = (RW+4)'({root_s[k], 2'b01});
				take  = (trial >= sub);
			end
			always_ff @(posedge clk) begin
				n_s[k+1]    <= n_s[k];
				rem_s[k+1]  <= take ? (RW+2)'(trial - sub) : (RW+2)'(trial);
				root_s[k+1] <= {root_s[k][RW-2:0], take};
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				n_s[k+1]    <= n_s[k];
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
		end
	end

	// Round to nearest with ties upward: remainder above root rounds up.
	assign root = (rem_s[DEPTH] > {2'b00, root_s[DEPTH]}) ?
		(RW+1)'(root_s[DEPTH]) + (RW+1)'(1) : (RW+1)'(root_s[DEPTH]);

endmodule

[hdl/pesd_cordic.sv]
// ----------------------------------------------------------------------------
// Pose error bearing CORDIC
// Unrolled vectoring CORDIC that turns an offset into its bearing in
// units of 2^-16 degree, one rotation per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pesd_cordic #(
	parameter int POS_WIDTH = 20,
	parameter int STEPS     = 20,
	parameter int DEPTH     = 22
) (
	input  logic                       clk,
	input  logic signed [POS_WIDTH:0]  dx,
	input  logic signed [POS_WIDTH:0]  dy,
	output logic signed [pesd_pkg::Z_WIDTH-1:0] bearing
);
	import pesd_pkg::*;

	localparam int XW = POS_WIDTH + 11;

	logic signed [XW-1:0]      x_s [DEPTH+1];
	logic signed [XW-1:0]      y_s [DEPTH+1];
	logic signed [Z_WIDTH-1:0] z_s [DEPTH+1];

	logic signed [XW-1:0] x_in;
	logic signed [XW-1:0] y_in;

	assign x_in = XW'(dx) <<< 8;
	assign y_in = XW'(dy) <<< 8;

	// Fold the left half plane over and start at a half turn.
	always_ff @(posedge clk) begin
		if (x_in < 0) begin
			x_s[0] <= -x_in;
			y_s[0] <= -y_in;
			z_s[0] <= Z_WIDTH'(FINE_HALF);
		end else begin
			x_s[0] <= x_in;
			y_s[0] <= y_in;
			z_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		if (k < STEPS) begin : g_rot
			// Rotate toward the x axis by atan(2^-k).
			always_ff @(posedge clk) begin
				if (!y_s[k][XW-1]) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + Z_WIDTH'(atan_fine(k));
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - Z_WIDTH'(atan_fine(k));
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				x_s[k+1] <= x_s[k];
				y_s[k+1] <= y_s[k];
				z_s[k+1] <= z_s[k];
			end
		end
	end

	assign bearing = z_s[DEPTH-1 + 1];

endmodule

[hdl/pesd_mod.sv]
// ----------------------------------------------------------------------------
// Pose error turn reduction
// Reduces a signed angle in 1/256 degree to the range of one turn
// (0 to 92159) in four pipeline stages, carrying the side-band along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pesd_mod #(
	parameter int VW = 26
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [VW-1:0]            angle_in,
	input  pesd_pkg::side_t                 side_in,
	output logic [pesd_pkg::MOD_WIDTH-1:0]  turn_out,
	output pesd_pkg::side_t                 side_out
);
	import pesd_pkg::*;

	localparam int UW = VW + 1;
	localparam longint OFFSET =
		(((longint'(1) <<< (VW-1)) + TURN_UNITS - 1) / TURN_UNITS) * TURN_UNITS;

	logic [UW-1:0]  biased;
	logic [23:0]    q_s1;
	logic [10:0]    lo_s1;
	logic [12:0]    sum_s2;
	logic [10:0]    lo_s2;
	logic [29:0]    prod_s3;
	logic [12:0]    sum_s3;
	logic [10:0]    lo_s3;
	logic [7:0]     quot;
	logic [12:0]    rest;
	logic [MOD_WIDTH-1:0] turn_s4;
	side_t          side_s1;
	side_t          side_s2;
	side_t          side_s3;
	side_t          side_s4;

	// Bias by whole turns so the value is never negative.
	assign biased = UW'(angle_in) + UW'(OFFSET);

	// The turn is 2048 * 45; since 4096 leaves 1 modulo 45, the
	// 12-bit chunks of the upper part may simply be added.
	always_ff @(posedge clk) begin
		q_s1    <= 24'(biased[UW-1:TURN_LOW_BITS]);
		lo_s1   <= biased[TURN_LOW_BITS-1:0];
		sum_s2  <= 13'(q_s1[11:0]) + 13'(q_s1[23:12]);
		lo_s2   <= lo_s1;
		prod_s3 <= 30'(sum_s2) * 30'(RECIP_45);
		sum_s3  <= sum_s2;
		lo_s3   <= lo_s2;
		turn_s4 <= {rest[5:0], lo_s3};
	end

	// Reciprocal quotient is exact for all 13-bit sums.
	assign quot = prod_s3[29:RECIP_SHIFT];
	assign rest = sum_s3 - 13'(quot) * 13'(TURN_ODD);

	// Side-band follows the data stage by stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	assign turn_out = turn_s4;
	assign side_out = side_s4;

endmodule

[hdl/pose_error_signed_distance.sv]
// ----------------------------------------------------------------------------
// Pose error signed distance
// Linear signed distance or wrapped heading error between two poses.
// ----------------------------------------------------------------------------
// A new beat may be started in every clock cycle and busy stays low. Each
// beat gives one result strobe on done. Its path runs through the two
// iteration pipelines, the bit-per-stage square root and the
// rotation-per-stage CORDIC, both as deep as the longer of the two, and
// then through the four-stage turn reduction. The receiver cannot stall,
// so results are simply presented in acceptance order. Write mode only
// while no beat is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pose_error_signed_distance #(
	parameter int POS_WIDTH    = 20,
	parameter int ANGLE_WIDTH  = 24,
	parameter int CORDIC_STEPS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [POS_WIDTH-1:0]    tgt_x,
	input  logic signed [POS_WIDTH-1:0]    tgt_y,
	input  logic signed [ANGLE_WIDTH-1:0]  target_angle,
	input  logic signed [POS_WIDTH-1:0]    cur_x,
	input  logic signed [POS_WIDTH-1:0]    cur_y,
	input  logic signed [ANGLE_WIDTH-1:0]  current_angle,
	output logic                           done,
	output logic signed [pesd_pkg::OUT_WIDTH-1:0] err_val
);
	import pesd_pkg::*;

	localparam int DEPTH = pesd_depth(POS_WIDTH, CORDIC_STEPS);
	localparam int SD    = DEPTH + 1;
	localparam int RW    = POS_WIDTH + 1;
	localparam int RXW   = (RW + 1 > OUT_WIDTH) ? RW + 1 : OUT_WIDTH;
	localparam int DW    = ((Z_WIDTH > ANGLE_WIDTH + 8) ? Z_WIDTH : ANGLE_WIDTH + 8) + 1;
	localparam int VW    = ANGLE_WIDTH + 2;

	logic mode_q;

	logic                            valid_s1;
	logic                            mode_s1;
	logic signed [POS_WIDTH:0]       dx_s1;
	logic signed [POS_WIDTH:0]       dy_s1;
	logic signed [ANGLE_WIDTH:0]     adiff_s1;
	logic signed [ANGLE_WIDTH-1:0]   ca_s1;

	logic                            dl_valid [1:SD];
	logic                            dl_mode  [1:SD];
	logic signed [ANGLE_WIDTH:0]     dl_adiff [1:SD];
	logic signed [ANGLE_WIDTH-1:0]   dl_ca    [1:SD];

	logic [RW:0]                     root;
	logic signed [Z_WIDTH-1:0]       bearing;
	logic [RXW-1:0]                  root_ext;
	logic [DIST_WIDTH-1:0]           dist_c;
	logic signed [DW-1:0]            fine_diff;
	logic signed [VW-1:0]            angle_c;

	logic signed [VW-1:0]            angle_s3;
	side_t                           side_s3;

	logic [MOD_WIDTH-1:0]            turn;
	side_t                           side_m;
	logic [FINE_WIDTH-1:0]           fine_m;
	logic                            backward;
	logic signed [OUT_WIDTH-1:0]     ang_err;
	logic signed [OUT_WIDTH-1:0]     lin_err;

	assign busy = 1'b0;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	// Stage 1: position offsets and raw heading difference.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1  <= mode_q;
		dx_s1    <= (POS_WIDTH+1)'(tgt_x) - (POS_WIDTH+1)'(cur_x);
		dy_s1    <= (POS_WIDTH+1)'(tgt_y) - (POS_WIDTH+1)'(cur_y);
		adiff_s1 <= (ANGLE_WIDTH+1)'(target_angle) - (ANGLE_WIDTH+1)'(current_angle);
		ca_s1    <= current_angle;
	end

	// Stage 2: distance root and bearing run side by side.
	pesd_sqrt #(
		.POS_WIDTH (POS_WIDTH),
		.DEPTH     (DEPTH)
	) u_sqrt (
		.clk  (clk),
		.dx   (dx_s1),
		.dy   (dy_s1),
		.root (root)
	);

	pesd_cordic #(
		.POS_WIDTH (POS_WIDTH),
		.STEPS     (CORDIC_STEPS),
		.DEPTH     (DEPTH)
	) u_cordic (
		.clk     (clk),
		.dx      (dx_s1),
		.dy      (dy_s1),
		.bearing (bearing)
	);

	// Delay line that keeps mode and headings in step with the units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= SD; i++) begin
				dl_valid[i] <= 1'b0;
			end
		end else begin
			dl_valid[1] <= valid_s1;
			for (int i = 2; i <= SD; i++) begin
				dl_valid[i] <= dl_valid[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dl_mode[1]  <= mode_s1;
		dl_adiff[1] <= adiff_s1;
		dl_ca[1]    <= ca_s1;
		for (int i = 2; i <= SD; i++) begin
			dl_mode[i]  <= dl_mode[i-1];
			dl_adiff[i] <= dl_adiff[i-1];
			dl_ca[i]    <= dl_ca[i-1];
		end
	end

	// Stage 3: saturate the distance and pick the angle to reduce.
	always_comb begin
		root_ext  = RXW'(root);
		dist_c    = (root_ext > RXW'(OUT_MAX)) ? DIST_WIDTH'(OUT_MAX)
			: root_ext[DIST_WIDTH-1:0];
		fine_diff = DW'(bearing) - (DW'(dl_ca[SD]) <<< 8);
		angle_c   = dl_mode[SD] ? VW'(dl_adiff[SD]) : VW'($signed(fine_diff[DW-1:8]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else begin
			side_s3.valid <= dl_valid[SD];
			side_s3.mode  <= dl_mode[SD];
			side_s3.low   <= dl_mode[SD] ? 8'd0 : fine_diff[7:0];
			side_s3.mag   <= dist_c;
		end
	end

	always_ff @(posedge clk) begin
		angle_s3 <= angle_c;
	end

	// Stage 4: reduce to one turn.
	pesd_mod #(
		.VW (VW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.angle_in (angle_s3),
		.side_in  (side_s3),
		.turn_out (turn),
		.side_out (side_m)
	);

	// Final stage: sign the distance or wrap the heading error.
	always_comb begin
		fine_m   = {turn, side_m.low};
		backward = (fine_m > FINE_WIDTH'(FINE_QUARTER))
			&& (fine_m < FINE_WIDTH'(FINE_THREE_QUARTER));
		ang_err  = (turn > MOD_WIDTH'(HALF_TURN_UNITS))
			? OUT_WIDTH'(turn) - OUT_WIDTH'(TURN_UNITS) : OUT_WIDTH'(turn);
		lin_err  = backward ? -$signed({1'b0, side_m.mag}) : $signed({1'b0, side_m.mag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= side_m.valid;
		end
	end

	always_ff @(posedge clk) begin
		err_val <= side_m.mode ? ang_err : lin_err;
	end

endmodule

[hdl/pesd_checker.sv]
// ----------------------------------------------------------------------------
// Pose error port checker
// Watches the top-level ports for result timing and output range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pose_error_signed_distance_assert.svh"

module pesd_checker #(
	parameter int POS_WIDTH    = 20,
	parameter int CORDIC_STEPS = 20
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [pesd_pkg::OUT_WIDTH-1:0] err_val
);
	import pesd_pkg::*;

	localparam int LAT = pesd_latency(POS_WIDTH, CORDIC_STEPS);
	localparam logic [OUT_WIDTH-1:0] MIN_CODE = {1'b1, {(OUT_WIDTH-1){1'b0}}};

	// Every accepted beat gives a strobe after the fixed latency.
	`PESD_ASSERT_DELAY(a_start_done, clk, arst_n, start && !busy, LAT, done)

	// No strobe appears without a beat accepted that long before.
	`PESD_ASSERT_IMPLY(a_done_had_start, clk, arst_n, done, $past(start && !busy, LAT))

	// Saturation keeps the result off the most negative code.
	`PESD_ASSERT_IMPLY(a_no_min_code, clk, arst_n, done, err_val != MIN_CODE)

endmodule

bind pose_error_signed_distance pesd_checker #(
	.POS_WIDTH    (POS_WIDTH),
	.CORDIC_STEPS (CORDIC_STEPS)
) u_pesd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.err_val (err_val)
);

[tb/pose_error_checker.sv]
// ----------------------------------------------------------------------------
// Pose error checker
// Watches the mode writes, the accepted beats and the result strobes of the
// pose error block, predicts every result and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pose_error_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  logic               start,
	input  logic               busy,
	input  logic signed [19:0] tgt_x,
	input  logic signed [19:0] tgt_y,
	input  logic signed [23:0] target_angle,
	input  logic signed [19:0] cur_x,
	input  logic signed [19:0] cur_y,
	input  logic signed [23:0] current_angle,
	input  logic               done,
	input  logic signed [21:0] err_val,
	output int                 mismatches,
	output int                 pending
);
	import pesd_pkg::*;

	localparam int STEPS = 20;
	localparam longint FULL_TURN_FINE = 64'd23592960;

	// Arctangent of 2^-i in 2^-16 degree.
	localparam longint ATAN_STEP [0:22] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
	};

	logic                      mode_shadow;
	logic signed [21:0]        err_q[$];

	function automatic longint wrap_mod(input longint v, input longint m);
		longint r;
		r = v % m;
		if (r < 0)
			r += m;
		return r;
	endfunction

	// Square root rounded to nearest, ties upward.
	function automatic longint root_rounded(input longint unsigned n);
		longint unsigned r, b, rem;
		r = 0;
		rem = n;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (rem > r)
			r += 1;
		return longint'(r);
	endfunction

	// CORDIC bearing of (dx, dy) in 2^-16 degree.
	function automatic longint bearing(input longint dx, input longint dy);
		longint x, y, z, xs, ys;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = FINE_HALF;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += (i < 23) ? ATAN_STEP[i] : 0;
			end else begin
				x -= ys;
				y += xs;
				z -= (i < 23) ? ATAN_STEP[i] : 0;
			end
		end
		return z;
	endfunction

	function automatic logic signed [21:0] predict_err(input logic md,
			input longint tx, input longint ty, input longint ta,
			input longint cx, input longint cy, input longint ca);
		longint dx, dy, ax, ay, mag, m;
		if (!md) begin
			dx = tx - cx;
			dy = ty - cy;
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			if (ax > OUT_MAX || ay > OUT_MAX)
				mag = OUT_MAX;
			else begin
				mag = root_rounded(longint'(ax * ax + ay * ay));
				if (mag > OUT_MAX)
					mag = OUT_MAX;
			end
			m = wrap_mod(bearing(dx, dy) - wrap_mod(ca, TURN_UNITS) * 256, FULL_TURN_FINE);
			return (m > FINE_QUARTER && m < FINE_THREE_QUARTER) ? 22'(-mag) : 22'(mag);
		end
		m = wrap_mod(ta - ca, TURN_UNITS);
		if (m > HALF_TURN_UNITS)
			m -= TURN_UNITS;
		return 22'(m);
	endfunction

	assign pending = err_q.size();

	// Track the mode, queue a prediction per beat, check each strobe.
	always @(posedge clk or negedge arst_n) begin
		logic signed [21:0] want;
		if (!arst_n) begin
			mode_shadow <= 1'b0;
			mismatches = 0;
			err_q.delete();
		end else begin
			if (cfg_we)
				mode_shadow <= cfg_data;
			if (done) begin
				if (err_q.size() == 0) begin
					$error("err_val: result %0d with none expected", err_val);
					mismatches++;
				end else begin
					want = err_q.pop_front();
					if (err_val !== want) begin
						$error("err_val: expected %0d, actual %0d", want, err_val);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				err_q.push_back(predict_err(mode_shadow, tgt_x,
					tgt_y, target_angle, cur_x, cur_y, current_angle));
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Pose error testbench top
// Drives directed and random pose pairs in both modes with random gaps and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import pesd_pkg::*;

	localparam int LATENCY = pesd_latency(20, 20);
	localparam logic MODE_LINEAR  = 1'b0;
	localparam logic MODE_ANGULAR = 1'b1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_data = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [19:0] tgt_x = '0, tgt_y = '0, cur_x = '0, cur_y = '0;
	logic signed [23:0] target_angle = '0, current_angle = '0;
	logic               done;
	logic signed [21:0] err_val;
	int                 mismatches, pending;
	bit                 no_gaps;

	always #10 clk = ~clk;

	pose_error_signed_distance dut (.*);
	pose_error_checker chk (.*);

	// Present one beat and hold it until accepted.
	task automatic send_pose(input logic [19:0] tx, input logic [19:0] ty,
			input logic [23:0] ta, input logic [19:0] cx, input logic [19:0] cy,
			input logic [23:0] ca);
		while (!no_gaps && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		tgt_x <= tx;
		tgt_y <= ty;
		target_angle <= ta;
		cur_x <= cx;
		cur_y <= cy;
		current_angle <= ca;
		@(posedge clk iff !busy);
	endtask

	// Drain the pipeline, then write the mode register.
	task automatic set_mode(input logic md);
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= md;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_pose();
		logic [19:0] cx, cy, tx, ty;
		logic [23:0] ca, ta;
		cx = $urandom;
		cy = $urandom;
		ca = $urandom;
		ta = $urandom;
		case ($urandom_range(3))
			0: begin
				tx = $urandom;
				ty = $urandom;
			end
			1: begin
				tx = cx + 20'($signed($urandom_range(64)) - 32);
				ty = cy + 20'($signed($urandom_range(64)) - 32);
			end
			2: begin
				tx = cx + 20'($signed($urandom_range(8192)) - 4096);
				ty = cy + 20'($signed($urandom_range(8192)) - 4096);
				ta = ca + 24'(46080 * ($signed($urandom_range(8)) - 4));
			end
			default: begin
				tx = cx;
				ty = cy + 20'($urandom_range(1000));
				ta = ca + 24'($signed($urandom_range(200)) - 100);
			end
		endcase
		send_pose(tx, ty, ta, cx, cy, ca);
	endtask

	task automatic directed_poses();
		send_pose(0, 0, 0, 0, 0, 0);
		send_pose(20'h7ffff, 20'h7ffff, 24'h7fffff, 20'h80000, 20'h80000, 24'h800000);
		send_pose(20'h80000, 20'h80000, 24'h800000, 20'h7ffff, 20'h7ffff, 24'h7fffff);
		send_pose(20'h7ffff, 0, 0, 20'h80000, 0, 0);
		send_pose(1000, 1000, 46080, 1000, 1000, 0);
		send_pose(0, 0, 0, 0, 0, 46080);
		send_pose(100, 0, 0, 0, 0, 0);
		send_pose(-100, 0, 0, 0, 0, 0);
		send_pose(0, 100, 0, 0, 0, 0);
		send_pose(0, -100, 0, 0, 0, 0);
		send_pose(3, 4, 23040, 0, 0, 0);
		send_pose(1, 1, -23040, 0, 0, -23040);
		send_pose(50, 0, 0, 0, 0, 23040);
		send_pose(0, 0, 46080, 0, 0, -46080);
		send_pose(-77, 123, 24'h7fffff, 5, -9, 1);
		send_pose(0, 0, 1, 0, 0, 46081);
		send_pose(2, 1, 0, 1, 2, 24'h800000);
	endtask

	initial begin
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(MODE_LINEAR);
		directed_poses();
		set_mode(MODE_ANGULAR);
		directed_poses();
		for (int ph = 0; ph < 6; ph++) begin
			set_mode(ph[0] ? MODE_LINEAR : MODE_ANGULAR);
			for (int n = 0; n < 236; n++) begin
				no_gaps = (ph == 2 && n >= 40 && n < 200);
				random_pose();
			end
		end
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Ends a hung run.
	initial begin
		#4ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
